[rtl/dq_pkg.sv]
`default_nettype none
package dq_pkg;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic END_FRONT = 1'b0;
  localparam logic END_REAR  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 5;

  typedef struct packed {
    logic wr;
    logic wr_rear;
    logic rd;
    logic rd_rear;
    logic pop;
    logic clear;
  } dq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dq_sts_t;

endpackage
`default_nettype wire

[rtl/dq_ram.sv]
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/dq_dp.sv]
`default_nettype none
module dq_dp
  import dq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dq_cmd_t                      cmd,
  input  wire logic signed [WORD_BITS-1:0]  push_value,
  output dq_sts_t                           sts,
  output logic signed [WORD_BITS-1:0]       data_out,
  output logic [COUNT_BITS-1:0]             entry_count,
  output logic                              is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rd_sel_r;

  logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [ELEM_BITS-1:0] wdata, rdata;
  logic [ELEM_BITS+WORD_BITS-1:0] wr_ext, rd_ext;
  logic [CW+COUNT_BITS-1:0] count_ext;

  assign front_inc = (front_r == LAST) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST : front_r - AW'(1);
  assign rear_inc  = (rear_r == LAST) ? '0 : rear_r + AW'(1);
  assign rear_dec  = (rear_r == '0) ? LAST : rear_r - AW'(1);

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));

  assign wr_ext = {{ELEM_BITS{1'b0}}, push_value};
  assign wdata  = wr_ext[ELEM_BITS-1:0];
  assign we     = cmd.wr;
  assign waddr  = cmd.wr_rear ? rear_r : front_dec;
  assign raddr  = cmd.rd_rear ? rear_dec : front_r;

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      front_nxt = '0;
      rear_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.wr) begin
      if (cmd.wr_rear) begin
        rear_nxt = rear_inc;
      end else begin
        front_nxt = front_dec;
      end
      count_nxt = count_r + CW'(1);
    end else if (cmd.rd && cmd.pop) begin
      if (cmd.rd_rear) begin
        rear_nxt = rear_dec;
      end else begin
        front_nxt = front_inc;
      end
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      count_r  <= '0;
      rd_sel_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      rear_r   <= rear_nxt;
      count_r  <= count_nxt;
      rd_sel_r <= cmd.rd;
    end
  end

  dq_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ext      = {{WORD_BITS{rdata[ELEM_BITS-1]}}, rdata};
  assign data_out    = rd_sel_r ? signed'(rd_ext[WORD_BITS-1:0]) : '0;
  assign count_ext   = {{COUNT_BITS{1'b0}}, count_r};
  assign entry_count = count_ext[COUNT_BITS-1:0];
  assign is_empty    = (count_r == '0);

endmodule
`default_nettype wire

[rtl/dq_ctrl.sv]
`default_nettype none
module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] operation,
  input  wire logic       end_select,
  input  wire dq_sts_t    sts,
  output dq_cmd_t         cmd,
  output logic            busy,
  output logic            out_valid,
  output logic [1:0]      status
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t     state_r;
  logic       valid_r;
  logic [1:0] status_r;
  logic [1:0] status_nxt;
  logic       accept;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    status_nxt = ST_OK;
    if (accept) begin
      case (operation)
        OP_PUSH: begin
          if (sts.full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.wr      = 1'b1;
            cmd.wr_rear = (end_select == END_REAR);
          end
        end
        OP_POP, OP_PEEK: begin
          if (sts.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.rd      = 1'b1;
            cmd.rd_rear = (end_select == END_REAR);
            cmd.pop     = (operation == OP_POP);
          end
        end
        OP_CLEAR: begin
          cmd.clear = 1'b1;
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= 1'b0;
      status_r <= ST_OK;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r  <= S_RESP;
            valid_r  <= 1'b1;
            status_r <= status_nxt;
          end
        end
        S_RESP: begin
          state_r <= S_IDLE;
          valid_r <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = (state_r == S_RESP);
  assign out_valid = valid_r;
  assign status    = status_r;

endmodule
`default_nettype wire

[rtl/double_ended_queue_core.sv]
// A word accepted at a clock edge is presented on out_* for the following cycle.
// busy is high while the result is shown, since the controller enters its response state
// S_RESP after every accepted word; no new word is taken until it returns to S_IDLE.
// The receiver cannot stall: out_valid pulses for exactly one cycle per word.
// Reset (rst_n low, synchronous) empties the queue; ring contents are not cleared.
`default_nettype none
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_operation,
  input  wire logic                        in_end_select,
  input  wire logic signed [WORD_BITS-1:0] in_push_value,
  output logic                             out_valid,
  output logic signed [WORD_BITS-1:0]      out_data_out,
  output logic [1:0]                       out_status,
  output logic [COUNT_BITS-1:0]            out_entry_count,
  output logic                             out_is_empty
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .operation  (in_operation),
    .end_select (in_end_select),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .status     (out_status)
  );

  dq_dp #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .push_value  (in_push_value),
    .sts         (sts),
    .data_out    (out_data_out),
    .entry_count (out_entry_count),
    .is_empty    (out_is_empty)
  );

`ifndef SYNTHESIS
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("accepted word produced no result");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == busy)
    else $error("busy does not track result cycle");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_is_empty && out_data_out == '0)
    else $error("empty error with stored words or data");
`endif

endmodule
`default_nettype wire
